FILE: rtl/mcbf_pkg.sv
// Package for the multi-channel byte FIFO table.
// Types, sizes and op/status codes. No dependencies.
`default_nettype none
package mcbf_pkg;
  localparam int NUM_CHANNELS  = 16;
  localparam int CHANNEL_BYTES = 1024;
  localparam int SLOT_W  = $clog2(NUM_CHANNELS);
  localparam int PTR_W   = $clog2(CHANNEL_BYTES);
  localparam int LVL_W   = $clog2(CHANNEL_BYTES + 1);
  localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
  localparam int ADDR_W  = SLOT_W + PTR_W;
  localparam int DEPTH   = NUM_CHANNELS * CHANNEL_BYTES;
  localparam logic [15:0] FIRST_AUTO_ID = 16'd10;
  localparam int QDEPTH = 2;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_AUTO   = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_EOF    = 3'd3;
  localparam logic [2:0] OP_WRITE  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ID     = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_CHAN_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_EOF        = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] chan_id;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      id_out;
    logic [7:0]       read_data;
    logic [10:0]      fill_level;
  } rsp_t;
endpackage
`default_nettype wire

FILE: rtl/multi_channel_byte_fifo_table.sv
// Top level of the multi-channel byte FIFO table.
// Uses mcbf_pkg, mcbf_queue and mcbf_engine.
//
// Requests enter on req_valid_i/req_ready_o with a req_t payload (op,
// chan_id, write_data); every request yields one rsp_t on rsp_valid_o/
// rsp_ready_i. A two-entry queue takes requests while the engine works.
// The engine takes one request at a time; a read with data passes an extra
// state for the byte store read port, and create-lowest-free rescans once
// per candidate id already in use (id scan loop). The response waits
// in its register while the receiver stalls; the queue keeps accepting
// until it holds two requests.
// Reset empties the queue and frees all channels. The byte store has no
// reset; bytes are read only after being written.
`default_nettype none
module multi_channel_byte_fifo_table import mcbf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  req_t      req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);
  logic q_valid, q_ready;
  req_t q_data;
  mcbf_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(req_valid_i), .in_ready_o(req_ready_o),
    .in_data_i(req_i), .out_valid_o(q_valid), .out_ready_i(q_ready),
    .out_data_o(q_data));
  mcbf_engine u_engine (
    .clk_i, .rst_ni, .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_data),
    .rsp_valid_o, .rsp_ready_i, .rsp_o);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status <= ST_EOF) else $error("bad status");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_OK |-> rsp_o.read_data == 8'd0)
    else $error("read data on failure");
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.fill_level <= 11'(CHANNEL_BYTES)) else $error("level");
endmodule
`default_nettype wire

FILE: rtl/mcbf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/mcbf_queue.sv
// Short request queue between the front and back parts.
// Uses mcbf_pkg.
`default_nettype none
module mcbf_queue import mcbf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  req_t      in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output req_t      out_data_o
);
  req_t buf_q [QDEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  assign in_ready_o  = cnt_q != 2'(QDEPTH);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = buf_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i) if (push) buf_q[wp_q] <= in_data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mcbf_engine.sv
// Back part: slot table, pointers and byte store; executes one request.
// Uses mcbf_pkg and mcbf_ram.
`default_nettype none
module mcbf_engine import mcbf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  req_t      req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_MEM = 2'd2, S_OUT = 2'd3;
  logic [1:0] st_q;
  logic [15:0] ids_q [NUM_CHANNELS];
  logic [PTR_W-1:0] head_q [NUM_CHANNELS];
  logic [PTR_W-1:0] tail_q [NUM_CHANNELS];
  logic [LVL_W-1:0] lvl_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] eof_q;
  logic [CNT_W-1:0] used_q;
  req_t r_q;
  logic [15:0] cand_q;
  rsp_t rsp_q;

  logic hit, free_any, cand_hit;
  logic [SLOT_W-1:0] hit_s, free_s;
  logic [15:0] key;
  assign key = r_q.chan_id;
  always_comb begin
    hit = 1'b0; hit_s = '0; free_any = 1'b0; free_s = '0; cand_hit = 1'b0;
    for (int s = NUM_CHANNELS - 1; s >= 0; s--) begin
      if (ids_q[s] == key && key != 16'd0) begin hit = 1'b1; hit_s = SLOT_W'(s); end
      if (ids_q[s] == 16'd0) begin free_any = 1'b1; free_s = SLOT_W'(s); end
      if (ids_q[s] == cand_q) cand_hit = 1'b1;
    end
  end

  logic we;
  logic [ADDR_W-1:0] addr;
  logic [7:0] rdata;
  mcbf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(r_q.write_data), .rdata_o(rdata));

  logic full_t;
  assign full_t = used_q >= CNT_W'(NUM_CHANNELS);
  assign req_ready_o = st_q == S_IDLE;
  assign rsp_valid_o = st_q == S_OUT;
  assign rsp_o = rsp_q;

  always_comb begin
    we = 1'b0;
    addr = {hit_s, head_q[hit_s]};
    if (st_q == S_SCAN && r_q.op == OP_WRITE && hit && lvl_q[hit_s] < LVL_W'(CHANNEL_BYTES)) begin
      we = 1'b1; addr = {hit_s, tail_q[hit_s]};
    end
  end

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (32'(p) + 1 >= CHANNEL_BYTES) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) if (req_valid_i && req_ready_o) r_q <= req_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; used_q <= '0; eof_q <= '0; cand_q <= FIRST_AUTO_ID;
      rsp_q <= '0;
      for (int s = 0; s < NUM_CHANNELS; s++) begin
        ids_q[s] <= '0; head_q[s] <= '0; tail_q[s] <= '0; lvl_q[s] <= '0;
      end
    end else begin
      unique case (st_q)
        S_IDLE: if (req_valid_i) begin st_q <= S_SCAN; cand_q <= FIRST_AUTO_ID; end
        S_SCAN: begin
          rsp_q.status <= ST_BAD_ID;
          rsp_q.id_out <= r_q.chan_id;
          rsp_q.read_data <= '0;
          rsp_q.fill_level <= hit ? 11'(lvl_q[hit_s]) : 11'd0;
          st_q <= S_OUT;
          unique case (r_q.op)
            OP_CREATE: begin
              if (r_q.chan_id == 16'd0) rsp_q.status <= ST_BAD_ID;
              else if (full_t || !free_any) rsp_q.status <= ST_TABLE_FULL;
              else if (hit) rsp_q.status <= ST_BAD_ID;
              else begin
                rsp_q.status <= ST_OK; rsp_q.fill_level <= '0;
                ids_q[free_s] <= r_q.chan_id; head_q[free_s] <= '0;
                tail_q[free_s] <= '0; lvl_q[free_s] <= '0; eof_q[free_s] <= 1'b0;
                used_q <= used_q + CNT_W'(1);
              end
            end
            OP_AUTO: begin
              if (full_t || !free_any) begin
                rsp_q.status <= ST_TABLE_FULL; rsp_q.id_out <= '0; rsp_q.fill_level <= '0;
              end else if (cand_hit) begin
                cand_q <= cand_q + 16'd1; st_q <= S_SCAN;
              end else begin
                rsp_q.status <= ST_OK; rsp_q.id_out <= cand_q; rsp_q.fill_level <= '0;
                ids_q[free_s] <= cand_q; head_q[free_s] <= '0;
                tail_q[free_s] <= '0; lvl_q[free_s] <= '0; eof_q[free_s] <= 1'b0;
                used_q <= used_q + CNT_W'(1);
              end
            end
            OP_DELETE: if (hit) begin
              rsp_q.status <= ST_OK; rsp_q.fill_level <= '0;
              ids_q[hit_s] <= '0; head_q[hit_s] <= '0; tail_q[hit_s] <= '0;
              lvl_q[hit_s] <= '0; eof_q[hit_s] <= 1'b0;
              if (used_q != '0) used_q <= used_q - CNT_W'(1);
            end
            OP_EOF: if (hit) begin
              rsp_q.status <= ST_OK; eof_q[hit_s] <= 1'b1;
            end
            OP_WRITE: if (hit) begin
              if (lvl_q[hit_s] >= LVL_W'(CHANNEL_BYTES)) rsp_q.status <= ST_CHAN_FULL;
              else begin
                rsp_q.status <= ST_OK;
                rsp_q.fill_level <= 11'(lvl_q[hit_s] + LVL_W'(1));
                tail_q[hit_s] <= adv(tail_q[hit_s]);
                lvl_q[hit_s] <= lvl_q[hit_s] + LVL_W'(1);
              end
            end
            OP_READ: if (hit) begin
              if (lvl_q[hit_s] == '0) rsp_q.status <= eof_q[hit_s] ? ST_EOF : ST_EMPTY;
              else begin
                rsp_q.status <= ST_OK;
                rsp_q.fill_level <= 11'(lvl_q[hit_s] - LVL_W'(1));
                head_q[hit_s] <= adv(head_q[hit_s]);
                lvl_q[hit_s] <= lvl_q[hit_s] - LVL_W'(1);
                st_q <= S_MEM;
              end
            end
            default: ;
          endcase
        end
        S_MEM: begin rsp_q.read_data <= rdata; st_q <= S_OUT; end
        S_OUT: if (rsp_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
